// ===== rtl/core/ordered_list_insert_delete_search_assert.svh =====
// Assertion macros for the ordered list block
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define OLIST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olist: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define OLIST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olist: next-cycle check failed");

`endif

// ===== rtl/core/olist_pkg.sv =====
package olist_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 6;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ST_W     = 2;

  // Stream payload layout
  localparam int unsigned S_DATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W = ((5 + 6 + 7) / 8) * 8;
  localparam int unsigned M_IDX_LO = 0;
  localparam int unsigned M_CNT_LO = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_BAD_POSITION = 2'd2,
    ST_NOT_FOUND    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_SC_RD,
    S_SC_CMP,
    S_DONE
  } seq_state_e;

  // Entry RAM access, one read and one write port
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Finished operation handed to the output register
  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

// ===== rtl/core/olist_ram.sv =====
module olist_ram (
  input  logic                        clk_i,
  input  olist_pkg::mem_req_t         req_i,
  output logic [olist_pkg::VAL_W-1:0] rdata_o
);
  import olist_pkg::*;

  logic [VAL_W-1:0] mem_q [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/olist_seq.sv =====
module olist_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [olist_pkg::OP_W-1:0]         op_i,
  input  logic [olist_pkg::POS_W-1:0]        pos_i,
  input  logic signed [olist_pkg::VAL_W-1:0] val_i,
  output olist_pkg::res_t                    res_o,
  input  logic                               res_ready_i,
  output olist_pkg::mem_req_t                mem_req_o,
  input  logic [olist_pkg::VAL_W-1:0]        mem_rdata_i
);
  import olist_pkg::*;

  seq_state_e          state_q, state_d;
  logic [OP_W-1:0]     op_q;
  logic [POS_W-1:0]    pos_q;
  logic [VAL_W-1:0]    val_q;
  logic [CNT_W-1:0]    j_q, j_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  status_e             status_q, status_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    slot;
  logic [CNT_W-1:0]    pos_ext;
  logic                accept;

  assign accept  = in_valid_i && in_ready_o;
  assign pos_ext = CNT_W'(pos_q);
  assign slot    = pos_ext - CNT_W'(1);

  // State and list length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Operation operands, walk index, status and found index
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      pos_q <= pos_i;
      val_q <= val_i;
    end
    j_q      <= j_d;
    status_q <= status_d;
    idx_q    <= idx_d;
  end

  // Sequence at most one RAM access per cycle
  always_comb begin
    state_d         = state_q;
    j_d             = j_q;
    cnt_d           = cnt_q;
    status_d        = status_q;
    idx_d           = idx_q;
    in_ready_o      = 1'b0;
    mem_req_o       = '0;
    mem_req_o.waddr = j_q[IDX_W-1:0];
    mem_req_o.wdata = mem_rdata_i;
    res_o.valid     = 1'b0;
    res_o.status    = status_q;
    res_o.idx       = idx_q;
    res_o.count     = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d = ST_OK;
        idx_d    = '0;
        case (op_q)
          OP_INSERT: begin
            if (cnt_q >= CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else if (pos_q == '0 || pos_ext > cnt_q + CNT_W'(1)) begin
              status_d = ST_BAD_POSITION;
              state_d  = S_DONE;
            end else begin
              j_d     = cnt_q;
              state_d = S_UP_RD;
            end
          end
          OP_DELETE: begin
            if (pos_q == '0 || pos_ext > cnt_q) begin
              status_d = ST_BAD_POSITION;
              state_d  = S_DONE;
            end else begin
              j_d     = slot;
              state_d = S_DN_RD;
            end
          end
          OP_LOCATE: begin
            j_d     = '0;
            state_d = S_SC_RD;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      // Insert: move entries up from the tail, then drop the value in
      S_UP_RD: begin
        if (j_q > slot) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = IDX_W'(j_q - CNT_W'(1));
          state_d         = S_UP_WR;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = slot[IDX_W-1:0];
          mem_req_o.wdata = val_q;
          cnt_d           = cnt_q + CNT_W'(1);
          state_d         = S_DONE;
        end
      end
      S_UP_WR: begin
        mem_req_o.we = 1'b1;
        j_d          = j_q - CNT_W'(1);
        state_d      = S_UP_RD;
      end
      // Delete: pull entries down toward the removed slot
      S_DN_RD: begin
        if (j_q + CNT_W'(1) < cnt_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = IDX_W'(j_q + CNT_W'(1));
          state_d         = S_DN_WR;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_DONE;
        end
      end
      S_DN_WR: begin
        mem_req_o.we = 1'b1;
        j_d          = j_q + CNT_W'(1);
        state_d      = S_DN_RD;
      end
      // Locate: scan from the head, stop at the first match
      S_SC_RD: begin
        if (j_q < cnt_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = j_q[IDX_W-1:0];
          state_d         = S_SC_CMP;
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end
      end
      S_SC_CMP: begin
        if (mem_rdata_i == val_q) begin
          idx_d   = j_q[IDX_W-1:0];
          state_d = S_DONE;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_SC_RD;
        end
      end
      S_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ordered_list_insert_delete_search.sv =====
// Ordered list of up to 32 signed 32-bit entries held in a single-port-pair
// RAM. Each input transaction (tuser = operation) inserts at a 1-based
// position, deletes at a 1-based position, or locates the first entry equal
// to a value; each yields exactly one output transaction carrying status,
// found index and the entry count after the operation. One operation is in
// flight at a time: a sequencer walks the RAM one read or write per cycle.
// The shifting and scanning cost comes from the one RAM read port, whose
// registered data each step waits on. An output register holds the finished
// transaction, so the next input can be taken while the result waits.
module ordered_list_insert_delete_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] position, [37:6] value, upper bits zero
  input  logic [olist_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // [1:0] operation
  input  logic [olist_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [4:0] found_index, [10:5] entry_count, upper bits zero
  output logic [olist_pkg::M_DATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [olist_pkg::ST_W-1:0]        m_axis_tuser
);
  import olist_pkg::*;

  res_t                   res;
  logic                   res_ready;
  mem_req_t               mem_req;
  logic [VAL_W-1:0]       mem_rdata;
  logic                   out_valid_q;
  logic [ST_W-1:0]        out_status_q;
  logic [4:0]             out_idx_q;
  logic [5:0]             out_cnt_q;

  olist_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .pos_i       (s_axis_tdata[POS_W-1:0]),
    .val_i       (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  olist_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Take a result whenever the output register is empty or draining
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  // Hold the payload until the transaction is taken
  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_status_q <= res.status;
      out_idx_q    <= 5'(res.idx);
      out_cnt_q    <= 6'(res.count);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = M_DATA_W'({out_cnt_q, out_idx_q});

  `include "ordered_list_insert_delete_search_assert.svh"

  `OLIST_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `OLIST_ASSERT_IMP(a_full_means_capacity, clk_i, rst_ni, res.valid && res.status == ST_FULL, res.count == CNT_W'(CAPACITY))
  `OLIST_ASSERT_IMP(a_idx_zero_on_error, clk_i, rst_ni, res.valid && res.status != ST_OK, res.idx == '0)
  `OLIST_ASSERT_IMP(a_count_bounded, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[10:5] <= 6'(CAPACITY))

endmodule

// ===== tb/ordered_list_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the ordered list, keeps a private copy of
// the list, and compares every output transaction with the oldest prediction.
module ordered_list_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // [5:0] position, [37:6] value, upper bits zero
  input  logic [olist_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [1:0] operation
  input  logic [olist_pkg::OP_W-1:0]     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [4:0] found_index, [10:5] entry_count, upper bits zero
  input  logic [olist_pkg::M_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  input  logic [olist_pkg::ST_W-1:0]     m_axis_tuser,
  output int                             fail_count_o,
  output int                             pending_o
);
  import olist_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic [VAL_W-1:0] slots [CAPACITY];
  int               held;
  list_result_t     expected_q [$];
  list_result_t     got;
  list_result_t     want;

  // Apply one operation to the private list and return the result it yields
  function automatic list_result_t apply_op(input logic [OP_W-1:0]  op,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VAL_W-1:0] val);
    list_result_t res;
    int           p;
    int           j;
    bit           hit;
    res.status = ST_OK;
    res.index  = '0;
    res.count  = '0;
    p          = int'(pos);
    hit        = 1'b0;
    case (op)
      OP_INSERT: begin
        // Fullness wins over a bad position
        if (held >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (p < 1 || p > held + 1) begin
          res.status = ST_BAD_POSITION;
        end else begin
          for (j = held; j > p - 1; j--) slots[j] = slots[j-1];
          slots[p-1] = val;
          held++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > held) begin
          res.status = ST_BAD_POSITION;
        end else begin
          for (j = p - 1; j + 1 < held; j++) slots[j] = slots[j+1];
          held--;
        end
      end
      OP_LOCATE: begin
        // First match wins
        res.status = ST_NOT_FOUND;
        for (j = 0; j < held && !hit; j++) begin
          if (slots[j] == val) begin
            hit        = 1'b1;
            res.status = ST_OK;
            res.index  = IDX_W'(j);
          end
        end
      end
      default: begin
        // Unused code leaves the list alone
      end
    endcase
    res.count = CNT_W'(held);
    return res;
  endfunction

  task automatic note_failure(input string what, input list_result_t exp_r,
                              input list_result_t act_r);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s: expected status %0d index %0d count %0d,",
               $realtime, what, exp_r.status, exp_r.index, exp_r.count,
               " got status %0d index %0d count %0d",
               act_r.status, act_r.index, act_r.count);
    end
  endtask

  // Check results first so a result with nothing waiting is never masked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held         = 0;
      fail_count_o = 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.index  = m_axis_tdata[M_IDX_LO +: IDX_W];
        got.count  = m_axis_tdata[M_CNT_LO +: CNT_W];
        if (expected_q.size() == 0) begin
          want = '0;
          note_failure("result with no transaction pending", want, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) note_failure("result mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(apply_op(s_axis_tuser, s_axis_tdata[POS_W-1:0],
                                      s_axis_tdata[POS_W +: VAL_W]));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== tb/tb_ordered_list_insert_delete_search.sv =====
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete_search;
  import olist_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned     NUM_RANDOM = 800;

  typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIX} trend_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [OP_W-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]     m_axis_tuser;
  int                  fail_count;
  int                  pending_count;

  // Rough entry count, used to steer positions toward valid ones and to switch trends
  int                  shadow_len = 0;
  bit                  send_quiet = 1'b0;
  bit                  recv_quiet = 1'b0;

  ordered_list_insert_delete_search dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  ordered_list_checker list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #10 clk_i = ~clk_i;

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  // Favor extremes and a small pool so locates hit often
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4, 5:    return VAL_W'($urandom_range(1, 6));
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction after a random gap; return at the falling edge
  task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_DATA_W - POS_W - VAL_W){1'b0}}, val, pos};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    case (op)
      OP_INSERT:
        if (shadow_len < CAPACITY && pos >= 1 && pos <= shadow_len + 1) shadow_len++;
      OP_DELETE:
        if (pos >= 1 && pos <= shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  // Result side: stall a random number of cycles before each transaction
  initial begin
    int stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned      sent;
    int               roll;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    trend_e           trend;
    bit               paused;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty list, bounds, signed extremes, duplicates, unused code
    send_op(OP_DELETE, 6'd1,  32'd0);
    send_op(OP_LOCATE, 6'd0,  32'd0);
    send_op(OP_INSERT, 6'd0,  32'd7);
    send_op(OP_INSERT, 6'd2,  32'd7);
    send_op(OP_INSERT, 6'd1,  32'h7fff_ffff);
    send_op(OP_INSERT, 6'd1,  32'h8000_0000);
    send_op(OP_INSERT, 6'd3,  32'hffff_ffff);
    send_op(OP_INSERT, 6'd2,  32'd0);
    send_op(OP_INSERT, 6'd6,  32'd9);
    send_op(OP_LOCATE, 6'd0,  32'h8000_0000);
    send_op(OP_LOCATE, 6'd63, 32'hffff_ffff);
    send_op(OP_LOCATE, 6'd0,  32'h7fff_ffff);
    send_op(OP_LOCATE, 6'd0,  32'd12345);
    send_op(OP_UNUSED, 6'd63, 32'hffff_ffff);
    send_op(OP_DELETE, 6'd63, 32'd0);
    send_op(OP_DELETE, 6'd0,  32'd0);
    send_op(OP_DELETE, 6'd5,  32'd0);
    send_op(OP_DELETE, 6'd4,  32'd0);
    send_op(OP_INSERT, 6'd4,  32'd5);
    send_op(OP_INSERT, 6'd1,  32'd5);
    send_op(OP_LOCATE, 6'd0,  32'd5);
    send_op(OP_DELETE, 6'd1,  32'd0);
    send_op(OP_LOCATE, 6'd0,  32'd5);
    send_op(OP_DELETE, 6'd2,  32'd0);

    // Random: swing the list between empty and full, with mixed stretches
    sent   = 0;
    trend  = TREND_GROW;
    paused = 1'b0;
    while (sent < NUM_RANDOM) begin
      if (trend == TREND_GROW && shadow_len == CAPACITY && $urandom_range(0, 5) == 0)
        trend = TREND_SHRINK;
      else if (trend == TREND_SHRINK && shadow_len == 0 && $urandom_range(0, 3) == 0)
        trend = $urandom_range(0, 1) ? TREND_MIX : TREND_GROW;
      else if (trend == TREND_MIX && $urandom_range(0, 59) == 0)
        trend = TREND_GROW;
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;

      roll = $urandom_range(0, 99);
      case (trend)
        TREND_GROW:   op = roll < 60 ? OP_INSERT : roll < 70 ? OP_DELETE :
                           roll < 98 ? OP_LOCATE : OP_UNUSED;
        TREND_SHRINK: op = roll < 10 ? OP_INSERT : roll < 60 ? OP_DELETE :
                           roll < 98 ? OP_LOCATE : OP_UNUSED;
        default:      op = roll < 35 ? OP_INSERT : roll < 70 ? OP_DELETE :
                           roll < 98 ? OP_LOCATE : OP_UNUSED;
      endcase

      if ($urandom_range(0, 9) == 0 || op == OP_LOCATE || op == OP_UNUSED)
        pos = POS_W'($urandom_range(0, 63));
      else if (op == OP_INSERT)
        pos = POS_W'($urandom_range(1, shadow_len + 1));
      else
        pos = shadow_len > 0 ? POS_W'($urandom_range(1, shadow_len)) : 6'd1;

      send_op(op, pos, pick_value());
      if (op != OP_UNUSED) sent++;

      // Let the block drain completely once mid-run
      if (!paused && sent == NUM_RANDOM / 2) begin
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow time for any stray result
    while (pending_count != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/olist_pkg.sv
rtl/core/olist_ram.sv
rtl/core/olist_seq.sv
rtl/core/ordered_list_insert_delete_search.sv
tb/ordered_list_checker.sv
tb/tb_ordered_list_insert_delete_search.sv
